// ===== rtl/ac3hp_pkg.sv =====
`default_nettype none
package ac3hp_pkg;

    localparam int OFFSET_BITS_DEF = 16;

    localparam logic [7:0] SYNC_BYTE0 = 8'h0b;
    localparam logic [7:0] SYNC_BYTE1 = 8'h77;

    // header_index values at which the first kept header byte arrives and at which the last header byte has been taken
    localparam logic [2:0] HDR_FIRST_KEPT = 3'd2;
    localparam logic [2:0] HDR_DONE       = 3'd6;

    localparam logic [4:0] BSID_MAX_OK   = 5'd11;
    localparam logic [4:0] BSID_BASE     = 5'd8;
    localparam logic [1:0] FSCOD_48K     = 2'd0;
    localparam logic [1:0] FSCOD_44K1    = 2'd1;
    localparam logic [1:0] FSCOD_32K     = 2'd2;
    localparam logic [1:0] FSCOD_BAD     = 2'd3;
    localparam logic [5:0] FRMSIZE_LIMIT = 6'd38;

    localparam logic [15:0] SR_48K  = 16'd48000;
    localparam logic [15:0] SR_44K1 = 16'd44100;
    localparam logic [15:0] SR_32K  = 16'd32000;

    localparam logic [31:0] OUT_OFFSET_MAX = 32'h0000_ffff;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SYNC  = 3'd1;
    localparam logic [2:0] ST_BAD_BSID = 3'd2;
    localparam logic [2:0] ST_BAD_FS   = 3'd3;
    localparam logic [2:0] ST_BAD_FRM  = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] sync_offset;
        logic [19:0] bitrate;
        logic [15:0] sample_rate;
        logic [11:0] frame_bytes;
        logic [2:0]  channels;
    } result_t;

    function automatic logic [19:0] rate_of(input logic [4:0] idx);
        logic [19:0] r;
        unique case (idx)
            5'd0:    r = 20'd32000;
            5'd1:    r = 20'd40000;
            5'd2:    r = 20'd48000;
            5'd3:    r = 20'd56000;
            5'd4:    r = 20'd64000;
            5'd5:    r = 20'd80000;
            5'd6:    r = 20'd96000;
            5'd7:    r = 20'd112000;
            5'd8:    r = 20'd128000;
            5'd9:    r = 20'd160000;
            5'd10:   r = 20'd192000;
            5'd11:   r = 20'd224000;
            5'd12:   r = 20'd256000;
            5'd13:   r = 20'd320000;
            5'd14:   r = 20'd384000;
            5'd15:   r = 20'd448000;
            5'd16:   r = 20'd512000;
            5'd17:   r = 20'd576000;
            5'd18:   r = 20'd640000;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] words48_of(input logic [4:0] idx);
        logic [10:0] w;
        unique case (idx)
            5'd0:    w = 11'd64;
            5'd1:    w = 11'd80;
            5'd2:    w = 11'd96;
            5'd3:    w = 11'd112;
            5'd4:    w = 11'd128;
            5'd5:    w = 11'd160;
            5'd6:    w = 11'd192;
            5'd7:    w = 11'd224;
            5'd8:    w = 11'd256;
            5'd9:    w = 11'd320;
            5'd10:   w = 11'd384;
            5'd11:   w = 11'd448;
            5'd12:   w = 11'd512;
            5'd13:   w = 11'd640;
            5'd14:   w = 11'd768;
            5'd15:   w = 11'd896;
            5'd16:   w = 11'd1024;
            5'd17:   w = 11'd1152;
            5'd18:   w = 11'd1280;
            default: w = 11'd0;
        endcase
        return w;
    endfunction

    function automatic logic [10:0] words441_of(input logic [4:0] idx);
        logic [10:0] w;
        unique case (idx)
            5'd0:    w = 11'd69;
            5'd1:    w = 11'd87;
            5'd2:    w = 11'd104;
            5'd3:    w = 11'd121;
            5'd4:    w = 11'd139;
            5'd5:    w = 11'd174;
            5'd6:    w = 11'd208;
            5'd7:    w = 11'd243;
            5'd8:    w = 11'd278;
            5'd9:    w = 11'd348;
            5'd10:   w = 11'd417;
            5'd11:   w = 11'd487;
            5'd12:   w = 11'd557;
            5'd13:   w = 11'd696;
            5'd14:   w = 11'd835;
            5'd15:   w = 11'd975;
            5'd16:   w = 11'd1114;
            5'd17:   w = 11'd1253;
            5'd18:   w = 11'd1393;
            default: w = 11'd0;
        endcase
        return w;
    endfunction

    function automatic logic [10:0] words32_of(input logic [4:0] idx);
        logic [10:0] w;
        unique case (idx)
            5'd0:    w = 11'd96;
            5'd1:    w = 11'd120;
            5'd2:    w = 11'd144;
            5'd3:    w = 11'd168;
            5'd4:    w = 11'd192;
            5'd5:    w = 11'd240;
            5'd6:    w = 11'd288;
            5'd7:    w = 11'd336;
            5'd8:    w = 11'd384;
            5'd9:    w = 11'd480;
            5'd10:   w = 11'd576;
            5'd11:   w = 11'd672;
            5'd12:   w = 11'd768;
            5'd13:   w = 11'd960;
            5'd14:   w = 11'd1152;
            5'd15:   w = 11'd1344;
            5'd16:   w = 11'd1536;
            5'd17:   w = 11'd1728;
            5'd18:   w = 11'd1920;
            default: w = 11'd0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] full_chans_of(input logic [2:0] acmod);
        logic [2:0] c;
        unique case (acmod)
            3'd0:    c = 3'd2;
            3'd1:    c = 3'd1;
            3'd2:    c = 3'd2;
            3'd3:    c = 3'd3;
            3'd4:    c = 3'd3;
            3'd5:    c = 3'd4;
            3'd6:    c = 3'd4;
            3'd7:    c = 3'd5;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    // lfeon position in {byte6, byte7}, after the optional mix level fields
    function automatic logic [3:0] lfe_bit_of(input logic [2:0] acmod);
        logic [3:0] b;
        unique case (acmod)
            3'd0:    b = 4'd12;
            3'd1:    b = 4'd12;
            3'd2:    b = 4'd10;
            3'd3:    b = 4'd10;
            3'd4:    b = 4'd10;
            3'd5:    b = 4'd8;
            3'd6:    b = 4'd10;
            3'd7:    b = 4'd8;
            default: b = 4'd12;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ac3hp_decode.sv =====
`default_nettype none
module ac3hp_decode
    import ac3hp_pkg::*;
(
    input  wire logic [7:0]  hdr_b4,
    input  wire logic [7:0]  hdr_b5,
    input  wire logic [7:0]  hdr_b6,
    input  wire logic [7:0]  hdr_b7,
    input  wire logic [15:0] offset,
    output result_t          res
);

    logic [1:0]  fscod;
    logic [5:0]  code;
    logic [4:0]  bsid;
    logic [2:0]  acmod;
    logic [4:0]  idx;
    logic [1:0]  br_shift;
    logic [10:0] words;
    logic [10:0] words_pad;
    logic [15:0] pair;

    assign fscod = hdr_b4[7:6];
    assign code  = hdr_b4[5:0];
    assign bsid  = hdr_b5[7:3];
    assign acmod = hdr_b6[7:5];
    assign idx   = code[5:1];
    assign pair  = {hdr_b6, hdr_b7};
    // bsid 9 to 11 halve the rate one to three times
    assign br_shift = (bsid > BSID_BASE) ? bsid[1:0] : 2'd0;

    always_comb begin
        words = words48_of(idx);
        unique case (fscod)
            FSCOD_48K:  words = words48_of(idx);
            FSCOD_44K1: words = words441_of(idx);
            FSCOD_32K:  words = words32_of(idx);
            default:    words = words48_of(idx);
        endcase
    end

    // odd codes at 44.1 kHz carry one padding word
    assign words_pad = words + ((fscod == FSCOD_44K1) ? {10'd0, code[0]} : 11'd0);

    always_comb begin
        res             = '0;
        res.sync_offset = offset;
        priority if (bsid > BSID_MAX_OK) begin
            res.status = ST_BAD_BSID;
        end else if (fscod == FSCOD_BAD) begin
            res.status = ST_BAD_FS;
        end else if (code >= FRMSIZE_LIMIT) begin
            res.status = ST_BAD_FRM;
        end else begin
            res.status      = ST_OK;
            res.bitrate     = rate_of(idx) >> br_shift;
            res.frame_bytes = {words_pad, 1'b0};
            res.channels    = full_chans_of(acmod) + {2'd0, pair[lfe_bit_of(acmod)]};
            unique case (fscod)
                FSCOD_48K:  res.sample_rate = SR_48K;
                FSCOD_44K1: res.sample_rate = SR_44K1;
                default:    res.sample_rate = SR_32K;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ac3hp_scan.sv =====
`default_nettype none
module ac3hp_scan
    import ac3hp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire in_item_t item,
    output logic          res_valid,
    output result_t       res
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    logic [7:0]             prev_reg, prev_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   sync_reg, sync_next;
    logic [2:0]             hidx_reg, hidx_next;
    logic                   given_reg, given_next;
    logic [7:0]             hb_reg [4];

    logic [7:0]             eff_prev;
    logic [OFFSET_BITS-1:0] eff_pos;
    logic                   eff_sync;
    logic [2:0]             eff_hidx;
    logic                   eff_given;
    logic                   hb_we;
    logic [2:0]             hb_sel;
    logic [31:0]            pos_wide;
    logic [15:0]            offset;
    result_t                dec_res;

    // first word of a buffer restarts the search before it is looked at
    assign eff_prev  = item.first_byte ? 8'd0 : prev_reg;
    assign eff_pos   = item.first_byte ? '0 : pos_reg;
    assign eff_sync  = item.first_byte ? 1'b0 : sync_reg;
    assign eff_hidx  = item.first_byte ? 3'd0 : hidx_reg;
    assign eff_given = item.first_byte ? 1'b0 : given_reg;

    assign pos_wide = 32'(eff_pos);
    assign offset   = (pos_wide > OUT_OFFSET_MAX) ? OUT_OFFSET_MAX[15:0] : pos_wide[15:0];
    assign hb_sel   = eff_hidx - HDR_FIRST_KEPT;

    ac3hp_decode u_decode (
        .hdr_b4 (hb_reg[0]),
        .hdr_b5 (hb_reg[1]),
        .hdr_b6 (hb_reg[2]),
        .hdr_b7 (item.data_byte),
        .offset (offset),
        .res    (dec_res)
    );

    always_comb begin
        prev_next  = prev_reg;
        pos_next   = pos_reg;
        sync_next  = sync_reg;
        hidx_next  = hidx_reg;
        given_next = given_reg;
        hb_we      = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        res.status = ST_NO_SYNC;
        if (step) begin
            prev_next  = eff_prev;
            pos_next   = eff_pos;
            sync_next  = eff_sync;
            hidx_next  = eff_hidx;
            given_next = eff_given;
            if (!eff_given) begin
                if (!eff_sync) begin
                    if (eff_pos != '0 && eff_prev == SYNC_BYTE0 &&
                        item.data_byte == SYNC_BYTE1) begin
                        sync_next = 1'b1;
                        hidx_next = 3'd0;
                        // position then holds the offset of the 0x0b
                        if (eff_pos != POS_MAX) begin
                            pos_next = eff_pos - OFFSET_BITS'(1);
                        end
                    end else begin
                        prev_next = item.data_byte;
                        if (eff_pos != POS_MAX) begin
                            pos_next = eff_pos + OFFSET_BITS'(1);
                        end
                    end
                    if (item.last_byte) begin
                        res_valid  = 1'b1;
                        given_next = 1'b1;
                    end
                end else begin
                    if (eff_hidx >= HDR_FIRST_KEPT && eff_hidx < HDR_DONE) begin
                        hb_we = 1'b1;
                    end
                    if (eff_hidx < HDR_DONE) begin
                        hidx_next = eff_hidx + 3'd1;
                    end
                    if (hidx_next == HDR_DONE) begin
                        res_valid  = 1'b1;
                        res        = dec_res;
                        given_next = 1'b1;
                    end else if (item.last_byte) begin
                        res_valid  = 1'b1;
                        given_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= 8'd0;
            pos_reg   <= '0;
            sync_reg  <= 1'b0;
            hidx_reg  <= 3'd0;
            given_reg <= 1'b0;
        end else begin
            prev_reg  <= prev_next;
            pos_reg   <= pos_next;
            sync_reg  <= sync_next;
            hidx_reg  <= hidx_next;
            given_reg <= given_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hb_we) begin
            hb_reg[hb_sel[1:0]] <= item.data_byte;
        end
    end

    a_idx_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !sync_reg |-> hidx_reg == 3'd0)
        else $error("header index moved without sync");

    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res_valid |=> given_reg)
        else $error("result given but buffer not closed");

    a_quiet_after: assert property (@(posedge aclk) disable iff (!aresetn)
        step && given_reg && !item.first_byte |-> !res_valid)
        else $error("second result in one buffer");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hidx_reg <= HDR_DONE)
        else $error("header index out of range");

endmodule
`default_nettype wire

// ===== rtl/ac3_sync_header_parser_top.sv =====
// channel | ports                                          | direction
// --------+------------------------------------------------+----------
// input   | s_valid s_ready s_data_byte s_first_byte       | in
//         | s_last_byte                                    |
// result  | m_valid m_ready m_status m_sync_offset         | out
//         | m_bitrate m_sample_rate m_frame_bytes m_channels |
//
// one word is taken every cycle while s_ready is high; a word passes an
// input register, then the search and header decode logic, then the result
// register
// aresetn clears the search state and both valid flags
// a stalled result holds the input register, so s_ready drops only while
// both registers are full and m_ready is low
`default_nettype none
module ac3_sync_header_parser_top
    import ac3hp_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_first_byte,
    input  wire logic        s_last_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [15:0]      m_sync_offset,
    output logic [19:0]      m_bitrate,
    output logic [15:0]      m_sample_rate,
    output logic [11:0]      m_frame_bytes,
    output logic [2:0]       m_channels
);

    logic     in_valid_reg, in_valid_next;
    in_item_t in_item_reg;
    logic     m_valid_reg, m_valid_next;
    result_t  m_res_reg;
    logic     advance;
    logic     res_valid;
    result_t  res;

    // the held word moves on once the result slot is free or being emptied
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    ac3hp_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = res_valid;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.data_byte  <= s_data_byte;
            in_item_reg.first_byte <= s_first_byte;
            in_item_reg.last_byte  <= s_last_byte;
        end
        if (advance && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_res_reg.status;
    assign m_sync_offset = m_res_reg.sync_offset;
    assign m_bitrate     = m_res_reg.bitrate;
    assign m_sample_rate = m_res_reg.sample_rate;
    assign m_frame_bytes = m_res_reg.frame_bytes;
    assign m_channels    = m_res_reg.channels;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !advance)
        else $error("pending result would be overwritten");

    a_load: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res_valid |=> m_valid_reg)
        else $error("result lost on load");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg && !s_valid |=> !in_valid_reg)
        else $error("input register filled without a word");

endmodule
`default_nettype wire

// ===== verif/ac3_sync_header_parser_top_tb.sv =====
`default_nettype none
module ac3_sync_header_parser_top_tb;
    import ac3hp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned LONG_HOLD   = 120;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned MAX_PRINTS  = 100;
    localparam logic [OFFSET_BITS_DEF-1:0] POS_SAT = '1;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_first_byte = 1'b0;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [15:0] m_sync_offset;
    logic [19:0] m_bitrate;
    logic [15:0] m_sample_rate;
    logic [11:0] m_frame_bytes;
    logic [2:0]  m_channels;

    ac3_sync_header_parser_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_sync_offset (m_sync_offset),
        .m_bitrate     (m_bitrate),
        .m_sample_rate (m_sample_rate),
        .m_frame_bytes (m_frame_bytes),
        .m_channels    (m_channels)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // pending buffer words and expected header results
    in_item_t    byte_q[$];
    result_t     header_results_q[$];
    logic [7:0]  frame_buf[$];
    int unsigned words_queued = 0;
    int unsigned err_cnt = 0;
    int unsigned cycle_cnt = 0;

    bit          tx_idle_en = 1'b0;
    bit          rx_idle_en = 1'b0;
    bit          long_hold_go = 1'b0;
    bit          long_hold_seen = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_hold = 0;

    // parser state as seen by the predictor
    logic [7:0]                 prev_q = 8'h00;
    logic [OFFSET_BITS_DEF-1:0] pos_q = '0;
    logic                       synced = 1'b0;
    logic [2:0]                 hdr_idx = 3'd0;
    logic [7:0]                 hdr_b [4];
    logic                       done_q = 1'b0;

    function automatic int unsigned kbps_of(input logic [4:0] idx);
        int unsigned k;
        case (idx)
            5'd0:    k = 32;
            5'd1:    k = 40;
            5'd2:    k = 48;
            5'd3:    k = 56;
            5'd4:    k = 64;
            5'd5:    k = 80;
            5'd6:    k = 96;
            5'd7:    k = 112;
            5'd8:    k = 128;
            5'd9:    k = 160;
            5'd10:   k = 192;
            5'd11:   k = 224;
            5'd12:   k = 256;
            5'd13:   k = 320;
            5'd14:   k = 384;
            5'd15:   k = 448;
            5'd16:   k = 512;
            5'd17:   k = 576;
            default: k = 640;
        endcase
        return k;
    endfunction

    function automatic result_t decode_header();
        result_t     r;
        logic [1:0]  fscod;
        logic [5:0]  code;
        logic [4:0]  bsid;
        logic [2:0]  acmod;
        logic [15:0] pair;
        int unsigned kbps;
        int unsigned words;
        int unsigned shamt;
        int unsigned lfe_pos;
        logic [31:0] off32;
        r = '0;
        fscod = hdr_b[0][7:6];
        code = hdr_b[0][5:0];
        bsid = hdr_b[1][7:3];
        acmod = hdr_b[2][7:5];
        pair = {hdr_b[2], hdr_b[3]};
        off32 = 32'(pos_q);
        r.sync_offset = 16'((off32 > OUT_OFFSET_MAX) ? OUT_OFFSET_MAX : off32);
        if (bsid > BSID_MAX_OK) begin
            r.status = ST_BAD_BSID;
        end else if (fscod == FSCOD_BAD) begin
            r.status = ST_BAD_FS;
        end else if (code >= FRMSIZE_LIMIT) begin
            r.status = ST_BAD_FRM;
        end else begin
            r.status = ST_OK;
            kbps = kbps_of(code[5:1]);
            shamt = (bsid > BSID_BASE) ? bsid - BSID_BASE : 0;
            r.bitrate = 20'((kbps * 1000) >> shamt);
            case (fscod)
                FSCOD_48K: begin
                    r.sample_rate = SR_48K;
                    words = kbps * 2;
                end
                FSCOD_44K1: begin
                    // 16-bit words per frame at 44.1 kHz, odd codes pad one word
                    r.sample_rate = SR_44K1;
                    words = kbps * 320 / 147 + code[0];
                end
                default: begin
                    r.sample_rate = SR_32K;
                    words = kbps * 3;
                end
            endcase
            r.frame_bytes = 12'(words * 2);
            r.channels = (acmod == 3'd1) ? 3'd1 : (acmod[0] ? 3'd3 : 3'd2);
            if (acmod[2])
                r.channels = r.channels + (acmod[1] ? 3'd2 : 3'd1);
            // lfeon moves down two bits per optional mix level field
            lfe_pos = 12;
            if (acmod[0] && acmod != 3'd1)
                lfe_pos = lfe_pos - 2;
            if (acmod[2])
                lfe_pos = lfe_pos - 2;
            if (acmod == 3'd2)
                lfe_pos = lfe_pos - 2;
            if (pair[lfe_pos])
                r.channels = r.channels + 3'd1;
        end
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] d, input logic is_first, input logic is_last);
        result_t r;
        if (is_first) begin
            prev_q = 8'h00;
            pos_q = '0;
            synced = 1'b0;
            hdr_idx = 3'd0;
            done_q = 1'b0;
        end
        if (done_q)
            return;
        if (!synced) begin
            if (pos_q != 0 && prev_q == SYNC_BYTE0 && d == SYNC_BYTE1) begin
                synced = 1'b1;
                hdr_idx = 3'd0;
                if (pos_q != POS_SAT)
                    pos_q = pos_q - OFFSET_BITS_DEF'(1);
            end else begin
                prev_q = d;
                if (pos_q != POS_SAT)
                    pos_q = pos_q + OFFSET_BITS_DEF'(1);
            end
        end else begin
            if (hdr_idx >= HDR_FIRST_KEPT && hdr_idx < HDR_DONE)
                hdr_b[hdr_idx - HDR_FIRST_KEPT] = d;
            if (hdr_idx < HDR_DONE)
                hdr_idx = hdr_idx + 3'd1;
            if (hdr_idx == HDR_DONE) begin
                header_results_q.push_back(decode_header());
                done_q = 1'b1;
                return;
            end
        end
        if (is_last) begin
            r = '0;
            r.status = ST_NO_SYNC;
            header_results_q.push_back(r);
            done_q = 1'b1;
        end
    endtask

    task automatic report_err(input string msg);
        if (err_cnt < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_err($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // sender
    always @(posedge aclk) begin
        in_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                parse_byte(s_data_byte, s_first_byte, s_last_byte);
            if (!s_valid || s_ready) begin
                if (tx_gap != 0) begin
                    tx_gap = tx_gap - 1;
                    s_valid <= 1'b0;
                end else if (byte_q.size() != 0 && tx_idle_en && $urandom_range(0, 5) == 0) begin
                    tx_gap = $urandom_range(0, 4);
                    s_valid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    nxt = byte_q.pop_front();
                    s_valid <= 1'b1;
                    s_data_byte <= nxt.data_byte;
                    s_first_byte <= nxt.first_byte;
                    s_last_byte <= nxt.last_byte;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with an on-demand long hold-off
    always @(posedge aclk) begin
        if (long_hold_go != long_hold_seen) begin
            long_hold_seen = long_hold_go;
            rx_hold = LONG_HOLD;
        end
        if (rx_hold != 0) begin
            rx_hold = rx_hold - 1;
            m_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_hold = $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (header_results_q.size() == 0) begin
                report_err($sformatf("unexpected result status %0d offset %0d",
                                     m_status, m_sync_offset));
            end else begin
                want = header_results_q.pop_front();
                check_field("status", 32'(m_status), 32'(want.status));
                check_field("sync_offset", 32'(m_sync_offset), 32'(want.sync_offset));
                check_field("bitrate", 32'(m_bitrate), 32'(want.bitrate));
                check_field("sample_rate", 32'(m_sample_rate), 32'(want.sample_rate));
                check_field("frame_bytes", 32'(m_frame_bytes), 32'(want.frame_bytes));
                check_field("channels", 32'(m_channels), 32'(want.channels));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL ac3_sync_header_parser_top");
            $finish;
        end
    end

    task automatic add_word(input logic [7:0] d, input logic is_first, input logic is_last);
        in_item_t w;
        w.data_byte = d;
        w.first_byte = is_first;
        w.last_byte = is_last;
        byte_q.push_back(w);
        words_queued++;
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] v;
        v = 8'($urandom);
        if (v == SYNC_BYTE0)
            v = 8'h00;
        return v;
    endfunction

    // lead junk, sync word, two crc bytes, header bytes 4..7, ignored tail
    task automatic build_frame(input int unsigned lead, input logic [7:0] b4,
                               input logic [7:0] b5, input logic [7:0] b6,
                               input logic [7:0] b7, input int unsigned tail);
        int unsigned i;
        frame_buf.delete();
        for (i = 0; i < lead; i++)
            frame_buf.push_back(junk_byte());
        frame_buf.push_back(SYNC_BYTE0);
        frame_buf.push_back(SYNC_BYTE1);
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(b4);
        frame_buf.push_back(b5);
        frame_buf.push_back(b6);
        frame_buf.push_back(b7);
        for (i = 0; i < tail; i++)
            frame_buf.push_back(8'($urandom));
    endtask

    task automatic send_buffer(input int unsigned keep, input bit with_first,
                               input bit with_last);
        int unsigned i;
        for (i = 0; i < keep; i++)
            add_word(frame_buf[i], with_first && i == 0, with_last && i == keep - 1);
    endtask

    task automatic random_traffic(input int unsigned n_words);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned n;
        int unsigned i;
        logic [1:0]  fscod;
        logic [5:0]  code;
        logic [4:0]  bsid;
        stop_at = words_queued + n_words;
        while (words_queued < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 17) begin
                fscod = ($urandom_range(0, 9) == 0) ? FSCOD_BAD : 2'($urandom_range(0, 2));
                code = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(38, 63))
                                                   : 6'($urandom_range(0, 37));
                bsid = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(12, 31))
                                                   : 5'($urandom_range(0, 11));
                build_frame($urandom_range(0, 6), {fscod, code}, {bsid, 3'($urandom)},
                            8'($urandom), 8'($urandom), $urandom_range(0, 3));
                if (kind < 14)
                    send_buffer(frame_buf.size(), 1'b1, $urandom_range(0, 1));
                else
                    send_buffer($urandom_range(1, frame_buf.size() - 1), 1'b1, 1'b1);
            end else begin
                n = $urandom_range(1, 8);
                for (i = 0; i < n; i++)
                    add_word(8'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    // waits until every queued word is sent and every expected result is back
    task automatic drain();
        do
            @(negedge aclk);
        while (byte_q.size() != 0 || s_valid || header_results_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        int unsigned i;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;

        // words before any buffer start are searched from the reset state
        add_word(8'hff, 1'b0, 1'b0);
        add_word(SYNC_BYTE0, 1'b0, 1'b0);
        // header ends exactly on the last word, 48 kHz lowest code, lfe set
        build_frame(0, {FSCOD_48K, 6'd0}, {5'd8, 3'd0}, 8'b000_10000, 8'h00, 0);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        // 44.1 kHz odd top code, bsid 11, acmod 7 with lfe, tail ignored
        build_frame(3, {FSCOD_44K1, 6'd37}, {5'd11, 3'd7}, 8'b111_00001, 8'hff, 2);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        // 32 kHz, acmod 2 with lfe clear
        build_frame(1, {FSCOD_32K, 6'd36}, {5'd0, 3'd0}, 8'b010_00000, 8'h00, 0);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        // all three errors at once: bsid wins
        build_frame(0, {FSCOD_BAD, 6'h3f}, {5'd31, 3'd7}, 8'hff, 8'hff, 0);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        build_frame(0, {FSCOD_48K, 6'd2}, {5'd12, 3'd0}, 8'h00, 8'h00, 0);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        // bad fscod outranks bad frame size code
        build_frame(2, {FSCOD_BAD, 6'h3f}, {5'd8, 3'd0}, 8'h20, 8'h00, 0);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        build_frame(0, {FSCOD_44K1, 6'd38}, {5'd6, 3'd0}, 8'h40, 8'h00, 0);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        // buffer ends inside the header, then on the first sync byte
        build_frame(1, {FSCOD_48K, 6'd10}, {5'd8, 3'd0}, 8'h00, 8'h00, 0);
        send_buffer(5, 1'b1, 1'b1);
        send_buffer(2, 1'b1, 1'b1);
        add_word(SYNC_BYTE0, 1'b1, 1'b1);
        // a sync word split across two buffers does not count
        add_word(8'h12, 1'b1, 1'b0);
        add_word(SYNC_BYTE0, 1'b0, 1'b1);
        add_word(SYNC_BYTE1, 1'b1, 1'b0);
        add_word(8'h00, 1'b0, 1'b1);
        // repeated first sync byte
        add_word(SYNC_BYTE0, 1'b1, 1'b0);
        build_frame(0, {FSCOD_32K, 6'd1}, {5'd9, 3'd0}, 8'b101_00100, 8'h00, 0);
        send_buffer(frame_buf.size(), 1'b0, 1'b1);
        // new buffer start in the middle of a header
        build_frame(2, {FSCOD_44K1, 6'd4}, {5'd8, 3'd0}, 8'h00, 8'h00, 0);
        send_buffer(6, 1'b1, 1'b0);
        build_frame(0, {FSCOD_44K1, 6'd5}, {5'd10, 3'd0}, 8'b110_00100, 8'h00, 3);
        send_buffer(frame_buf.size(), 1'b1, 1'b1);
        // stray words after the result, sync and last included, are ignored
        add_word(SYNC_BYTE0, 1'b0, 1'b0);
        add_word(SYNC_BYTE1, 1'b0, 1'b1);
        drain();

        // long receiver stall while one-word buffers keep coming
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        long_hold_go = ~long_hold_go;
        for (i = 0; i < 40; i++)
            add_word(8'($urandom), 1'b1, 1'b1);
        drain();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        random_traffic(160);
        drain();
        random_traffic(160);
        drain();

        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        random_traffic(40);
        drain();

        if (err_cnt == 0)
            $display("PASS ac3_sync_header_parser_top");
        else
            $display("FAIL ac3_sync_header_parser_top");
        $finish;
    end

endmodule
`default_nettype wire
